/* rtl/deq_pkg.sv */
// double-ended queue package: command and status codes, default sizes
// used by double_ended_queue; depends on nothing else
`default_nettype none

package deq_pkg;

  localparam int DefaultDepth     = 64;
  localparam int DefaultDataWidth = 32;

  localparam int CmdWidth    = 3;
  localparam int ValueWidth  = 32;
  localparam int PosWidth    = 6;
  localparam int StatusWidth = 2;
  localparam int OccWidth    = 7;

  typedef enum logic [CmdWidth-1:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_READ_INDEX = 3'd4,
    CMD_CLEAR      = 3'd5
  } cmd_t;

  typedef enum logic [StatusWidth-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

endpackage

`default_nettype wire

/* rtl/deq_ram.sv */
// single-port synchronous entry store for the double-ended queue
// one access per cycle, registered read data; no package dependencies
`default_nettype none

module deq_ram #(
  parameter int DEPTH      = 64,
  parameter int DATA_WIDTH = 32
) (
  input  wire logic                          clk,
  input  wire logic                          en,
  input  wire logic                          we,
  input  wire logic [$clog2(DEPTH)-1:0]      addr,
  input  wire logic [DATA_WIDTH-1:0]         wdata,
  output logic      [DATA_WIDTH-1:0]         rdata
);

  logic [DATA_WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/double_ended_queue.sv */
// Bounded double-ended queue kept as a ring in a single-port synchronous store
// of DEPTH entries. Every command (push front/back, pop front/back, read at a
// position counted from the front, clear) takes at most one store access and
// gives one result: read_data, status and occupancy after the command. One
// command is accepted per cycle while in_stall is low; the result passes
// through the store read register and then the output register. Throughput is
// set by the one store port, which each command uses at most once. Pushing into
// a full queue is refused with status full; popping an empty queue gives status
// empty; a read at or beyond the occupancy gives status out of range. No
// clearing pass after reset: entries are only read once pushed.
// depends on deq_pkg and deq_ram
`default_nettype none

module double_ended_queue #(
  parameter int DEPTH      = deq_pkg::DefaultDepth,
  parameter int DATA_WIDTH = deq_pkg::DefaultDataWidth
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [deq_pkg::CmdWidth-1:0]    cmd,
  input  wire logic [deq_pkg::ValueWidth-1:0]  value,
  input  wire logic [deq_pkg::PosWidth-1:0]    position,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [deq_pkg::ValueWidth-1:0]       read_data,
  output logic [deq_pkg::StatusWidth-1:0]      status,
  output logic [deq_pkg::OccWidth-1:0]         occupancy
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = AW + 1;
  localparam int PW = (CW > deq_pkg::PosWidth) ? CW : deq_pkg::PosWidth;
  localparam int OW = (CW > deq_pkg::OccWidth) ? CW : deq_pkg::OccWidth;
  localparam int XW = (DATA_WIDTH > deq_pkg::ValueWidth) ? DATA_WIDTH
                                                         : deq_pkg::ValueWidth;

  logic [AW-1:0] front;
  logic [AW-1:0] front_next;
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;

  logic                    s1_valid;
  logic                    s1_use_rd;
  logic                    s1_use_rd_next;
  deq_pkg::status_t        s1_status;
  deq_pkg::status_t        s1_status_next;
  logic [CW-1:0]           s1_count;

  logic                    mem_en;
  logic                    mem_we;
  logic [AW-1:0]           mem_addr;
  logic [DATA_WIDTH-1:0]   mem_wdata;
  logic [DATA_WIDTH-1:0]   mem_rdata;

  logic                    accept;
  logic                    out_free;
  logic                    s1_move;
  logic                    is_empty;
  logic                    is_full;
  logic [AW-1:0]           front_dec;
  logic [AW-1:0]           front_inc;
  logic [PW-1:0]           pos_ext;
  logic [PW-1:0]           count_ext;
  logic [XW-1:0]           value_ext;
  logic [XW-1:0]           rdata_ext;
  logic [OW-1:0]           occ_ext;

  function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] base,
                                            input logic [CW-1:0] off);
    logic [SW-1:0] s;
    s = SW'(base) + SW'(off);
    if (s >= SW'(DEPTH)) begin
      s = s - SW'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

  assign out_free = !out_valid || !out_stall;
  assign s1_move  = s1_valid && out_free;
  assign in_stall = s1_valid && !out_free;
  assign accept   = in_valid && !in_stall;

  assign is_empty  = (count == '0);
  assign is_full   = (count == CW'(DEPTH));
  assign front_dec = (front == '0) ? AW'(DEPTH - 1) : front - 1'b1;
  assign front_inc = (SW'(front) + 1'b1 == SW'(DEPTH)) ? '0 : front + 1'b1;
  assign pos_ext   = PW'(position);
  assign count_ext = PW'(count);
  assign value_ext = XW'(value);
  assign mem_wdata = value_ext[DATA_WIDTH-1:0];

  // command decode: pointer update and the store access, if any
  always_comb begin
    front_next     = front;
    count_next     = count;
    s1_status_next = deq_pkg::ST_OK;
    s1_use_rd_next = 1'b0;
    mem_we         = 1'b0;
    mem_addr       = front;
    mem_en         = 1'b0;
    case (cmd)
      deq_pkg::CMD_PUSH_FRONT: begin
        if (is_full) begin
          s1_status_next = deq_pkg::ST_FULL;
        end else begin
          front_next = front_dec;
          count_next = count + 1'b1;
          mem_en     = 1'b1;
          mem_we     = 1'b1;
          mem_addr   = front_dec;
        end
      end
      deq_pkg::CMD_PUSH_BACK: begin
        if (is_full) begin
          s1_status_next = deq_pkg::ST_FULL;
        end else begin
          count_next = count + 1'b1;
          mem_en     = 1'b1;
          mem_we     = 1'b1;
          mem_addr   = slot_of(front, count);
        end
      end
      deq_pkg::CMD_POP_FRONT: begin
        if (is_empty) begin
          s1_status_next = deq_pkg::ST_EMPTY;
        end else begin
          front_next     = front_inc;
          count_next     = count - 1'b1;
          mem_en         = 1'b1;
          mem_addr       = front;
          s1_use_rd_next = 1'b1;
        end
      end
      deq_pkg::CMD_POP_BACK: begin
        if (is_empty) begin
          s1_status_next = deq_pkg::ST_EMPTY;
        end else begin
          count_next     = count - 1'b1;
          mem_en         = 1'b1;
          mem_addr       = slot_of(front, count - 1'b1);
          s1_use_rd_next = 1'b1;
        end
      end
      deq_pkg::CMD_READ_INDEX: begin
        if (pos_ext >= count_ext) begin
          s1_status_next = deq_pkg::ST_RANGE;
        end else begin
          mem_en         = 1'b1;
          mem_addr       = slot_of(front, pos_ext[CW-1:0]);
          s1_use_rd_next = 1'b1;
        end
      end
      deq_pkg::CMD_CLEAR: begin
        front_next = '0;
        count_next = '0;
      end
      default: begin
      end
    endcase
  end

  deq_ram #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ram (
    .clk   (clk),
    .en    (accept && mem_en),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      front     <= '0;
      count     <= '0;
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        front <= front_next;
        count <= count_next;
      end
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end
      if (s1_move) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign rdata_ext = XW'(mem_rdata);
  assign occ_ext   = OW'(s1_count);

  // result payload, held while the transfer is stalled
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_use_rd <= s1_use_rd_next;
      s1_status <= s1_status_next;
      s1_count  <= count_next;
    end
    if (s1_move) begin
      read_data <= s1_use_rd ? rdata_ext[deq_pkg::ValueWidth-1:0] : '0;
      status    <= s1_status;
      occupancy <= occ_ext[deq_pkg::OccWidth-1:0];
    end
  end

endmodule

`default_nettype wire
